// ===== hw/rtl/abs_pkg.sv =====
// Package for the alternating bit sender.
// Request codes, field widths and register reset values; no dependencies.
package abs_pkg;

  localparam int BYTE_W = 8;
  localparam int ACK_W  = 20;
  localparam int TICK_W = 16;
  localparam int CSUM_W = 13;
  localparam int REQ_W  = 2;

  localparam logic [REQ_W-1:0] REQ_MSG  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  localparam logic KIND_PKT  = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd10;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CSUM_W-1:0] csum_t;

endpackage

// ===== hw/rtl/abs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module abs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/alternating_bit_sender_core.sv =====
// Alternating bit (stop-and-wait) sender.
// Uses abs_pkg and abs_ram.
//
// Input channel (in_valid / in_stall): one request per beat - a message byte,
// an acknowledgement packet or a timer tick. Result channel (out_valid /
// out_stall): one packet byte per beat, or a single drop flag when a finished
// message finds the queue full. cfg_wr_en / cfg_wr_data set timeout_ticks.
//
// Message bytes are written straight into a slot of the message RAM, so a
// byte without a last mark does not stall the input. A packet send reads
// each of its bytes (up to MESSAGE_BYTES) from the RAM, then loads it into
// the output register; a dequeued message first fetches length and checksum.
// in_stall is high for the whole send. Slots form a ring of QUEUE_DEPTH+2:
// held packet, queued messages, message under assembly.
//
// Reset initialises all control state and sets timeout_ticks to 10; the RAMs are
// never read where not written, so they need no clearing. When the receiver
// stalls, the output register holds its beat and the send waits.
module alternating_bit_sender_core #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int MESSAGE_BYTES = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [abs_pkg::TICK_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [abs_pkg::REQ_W-1:0]   in_req_type,
  input  logic [abs_pkg::BYTE_W-1:0]  in_msg_byte,
  input  logic                        in_msg_last,
  input  logic [abs_pkg::ACK_W-1:0]   in_ack_number,
  input  logic [abs_pkg::ACK_W-1:0]   in_ack_seq_number,
  input  logic [abs_pkg::ACK_W-1:0]   in_ack_checksum,
  input  logic [abs_pkg::BYTE_W-1:0]  in_ack_payload_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic                        out_pkt_seq,
  output logic                        out_pkt_ack,
  output logic [abs_pkg::CSUM_W-1:0]  out_pkt_checksum,
  output logic [abs_pkg::BYTE_W-1:0]  out_payload_byte,
  output logic                        out_pkt_last
);

  localparam int NSLOT  = QUEUE_DEPTH + 2;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W  = $clog2(MESSAGE_BYTES + 1);
  localparam int BDEPTH = NSLOT * MESSAGE_BYTES;
  localparam int ADDR_W = $clog2(BDEPTH);
  localparam int LRAM_W = LEN_W + abs_pkg::CSUM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_LCAP = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DROP = 3'd5;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(NSLOT - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                  input logic [LEN_W-1:0] k);
    byte_addr = ADDR_W'(s) * ADDR_W'(MESSAGE_BYTES) + ADDR_W'(k);
  endfunction

  logic [2:0]                  state_r, state_nxt;
  logic [abs_pkg::TICK_W-1:0]  timeout_r;
  logic                        seq_r, seq_nxt;
  logic                        waiting_r, waiting_nxt;
  logic                        running_r, running_nxt;
  logic [abs_pkg::TICK_W-1:0]  tcount_r, tcount_nxt;
  logic [SLOT_W-1:0]           held_slot_r, held_slot_nxt;
  logic [SLOT_W-1:0]           asm_slot_r, asm_slot_nxt;
  logic [QC_W-1:0]             qcount_r, qcount_nxt;
  logic [LEN_W-1:0]            asm_len_r, asm_len_nxt;
  abs_pkg::csum_t              asm_sum_r, asm_sum_nxt;
  logic [LEN_W-1:0]            held_len_r, held_len_nxt;
  abs_pkg::csum_t              held_sum_r, held_sum_nxt;
  logic [LEN_W-1:0]            idx_r, idx_nxt;

  logic                        out_valid_r;
  logic                        out_kind_r, out_seq_r, out_last_r;
  abs_pkg::csum_t              out_csum_r;
  abs_pkg::byte_t              out_byte_r;

  logic                        accept, out_free, load_pkt, load_drop;
  logic                        byte_we, len_we, byte_re, len_re;
  logic                        fits;
  logic [LEN_W-1:0]            msg_len;
  abs_pkg::csum_t              msg_sum;
  logic [abs_pkg::ACK_W:0]     ack_sum;
  logic                        ack_good;
  logic [abs_pkg::TICK_W-1:0]  limit, tick_next;
  abs_pkg::byte_t              byte_rdata;
  logic [LRAM_W-1:0]           len_rdata;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign fits    = (asm_len_r < LEN_W'(MESSAGE_BYTES));
  assign msg_len = fits ? asm_len_r + 1'b1 : asm_len_r;
  assign msg_sum = fits ? asm_sum_r + abs_pkg::CSUM_W'(in_msg_byte) : asm_sum_r;

  assign ack_sum  = (abs_pkg::ACK_W+1)'(in_ack_seq_number) + (abs_pkg::ACK_W+1)'(in_ack_number)
                  + (abs_pkg::ACK_W+1)'(in_ack_payload_byte);
  assign ack_good = (in_ack_number == abs_pkg::ACK_W'(seq_r))
                 && ((abs_pkg::ACK_W+1)'(in_ack_checksum) == ack_sum);

  assign limit     = (timeout_r == '0) ? abs_pkg::TICK_W'(1) : timeout_r;
  assign tick_next = tcount_r + 1'b1;

  assign byte_we   = accept && (in_req_type == abs_pkg::REQ_MSG) && fits;
  assign byte_re   = (state_r == S_RD);
  assign len_re    = (state_r == S_LEN);
  assign load_pkt  = (state_r == S_WR) && out_free;
  assign load_drop = (state_r == S_DROP) && out_free;

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    waiting_nxt   = waiting_r;
    running_nxt   = running_r;
    tcount_nxt    = tcount_r;
    held_slot_nxt = held_slot_r;
    asm_slot_nxt  = asm_slot_r;
    qcount_nxt    = qcount_r;
    asm_len_nxt   = asm_len_r;
    asm_sum_nxt   = asm_sum_r;
    held_len_nxt  = held_len_r;
    held_sum_nxt  = held_sum_r;
    idx_nxt       = idx_r;
    len_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            abs_pkg::REQ_MSG: begin
              asm_len_nxt = msg_len;
              asm_sum_nxt = msg_sum;
              if (in_msg_last) begin
                asm_len_nxt = '0;
                asm_sum_nxt = '0;
                if (!waiting_r && qcount_r == '0) begin
                  // idle: the assembled slot becomes the held packet
                  held_slot_nxt = asm_slot_r;
                  asm_slot_nxt  = slot_inc(asm_slot_r);
                  held_len_nxt  = msg_len;
                  held_sum_nxt  = msg_sum;
                  waiting_nxt   = 1'b1;
                  running_nxt   = 1'b1;
                  tcount_nxt    = '0;
                  idx_nxt       = '0;
                  state_nxt     = S_RD;
                end else if (qcount_r < QC_W'(QUEUE_DEPTH)) begin
                  len_we       = 1'b1;
                  asm_slot_nxt = slot_inc(asm_slot_r);
                  qcount_nxt   = qcount_r + 1'b1;
                end else begin
                  state_nxt = S_DROP;
                end
              end
            end
            abs_pkg::REQ_ACK: begin
              if (waiting_r) begin
                if (ack_good) begin
                  seq_nxt     = !seq_r;
                  waiting_nxt = 1'b0;
                  running_nxt = 1'b0;
                  tcount_nxt  = '0;
                  if (qcount_r != '0) begin
                    held_slot_nxt = slot_inc(held_slot_r);
                    qcount_nxt    = qcount_r - 1'b1;
                    waiting_nxt   = 1'b1;
                    running_nxt   = 1'b1;
                    state_nxt     = S_LEN;
                  end
                end else begin
                  running_nxt = 1'b1;
                  tcount_nxt  = '0;
                  idx_nxt     = '0;
                  state_nxt   = S_RD;
                end
              end
            end
            abs_pkg::REQ_TICK: begin
              if (running_r) begin
                tcount_nxt = tick_next;
                if (tick_next >= limit) begin
                  tcount_nxt = '0;
                  idx_nxt    = '0;
                  state_nxt  = S_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LEN: begin
        state_nxt = S_LCAP;
      end
      S_LCAP: begin
        held_len_nxt = len_rdata[LRAM_W-1:abs_pkg::CSUM_W];
        held_sum_nxt = len_rdata[abs_pkg::CSUM_W-1:0];
        idx_nxt      = '0;
        state_nxt    = S_RD;
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_r + 1'b1 == held_len_r) ? S_IDLE : S_RD;
        end
      end
      S_DROP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= abs_pkg::TIMEOUT_RESET;
      seq_r       <= 1'b0;
      waiting_r   <= 1'b0;
      running_r   <= 1'b0;
      tcount_r    <= '0;
      held_slot_r <= '0;
      asm_slot_r  <= SLOT_W'(1);
      qcount_r    <= '0;
      asm_len_r   <= '0;
      asm_sum_r   <= '0;
      held_len_r  <= '0;
      held_sum_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      seq_r       <= seq_nxt;
      waiting_r   <= waiting_nxt;
      running_r   <= running_nxt;
      tcount_r    <= tcount_nxt;
      held_slot_r <= held_slot_nxt;
      asm_slot_r  <= asm_slot_nxt;
      qcount_r    <= qcount_nxt;
      asm_len_r   <= asm_len_nxt;
      asm_sum_r   <= asm_sum_nxt;
      held_len_r  <= held_len_nxt;
      held_sum_r  <= held_sum_nxt;
      idx_r       <= idx_nxt;
      if (load_pkt || load_drop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output beat register, payload only
  always_ff @(posedge clk) begin
    if (load_pkt) begin
      out_kind_r <= abs_pkg::KIND_PKT;
      out_seq_r  <= seq_r;
      out_csum_r <= held_sum_r + abs_pkg::CSUM_W'(seq_r);
      out_byte_r <= byte_rdata;
      out_last_r <= (idx_r + 1'b1 == held_len_r);
    end else if (load_drop) begin
      out_kind_r <= abs_pkg::KIND_DROP;
      out_seq_r  <= 1'b0;
      out_csum_r <= '0;
      out_byte_r <= '0;
      out_last_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_pkt_seq      = out_seq_r;
  assign out_pkt_ack      = 1'b0;
  assign out_pkt_checksum = out_csum_r;
  assign out_payload_byte = out_byte_r;
  assign out_pkt_last     = out_last_r;

  abs_ram #(
    .WIDTH (abs_pkg::BYTE_W),
    .DEPTH (BDEPTH)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_addr(asm_slot_r, asm_len_r)),
    .wdata (in_msg_byte),
    .re    (byte_re),
    .raddr (byte_addr(held_slot_r, idx_r)),
    .rdata (byte_rdata)
  );

  abs_ram #(
    .WIDTH (LRAM_W),
    .DEPTH (NSLOT)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (asm_slot_r),
    .wdata ({msg_len, msg_sum}),
    .re    (len_re),
    .raddr (held_slot_r),
    .rdata (len_rdata)
  );

  a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcount_r <= QC_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !waiting_r |-> (qcount_r == '0))
    else $error("messages queued while no ack awaited");

  a_timer_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    running_r == waiting_r)
    else $error("timer state out of step with ack wait");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (idx_r < held_len_r))
    else $error("send index past held length");

  a_send_sets_wait: assert property (@(posedge clk) disable iff (!rst_n)
    load_pkt |=> waiting_r)
    else $error("packet beat sent without ack wait");

endmodule
